### design/ices_pkg.sv
// shared constants, codes and types of the input change event scanner
package ices_pkg;

    // sensor lanes; the snapshot word carries at most sixteen levels
    localparam int SensorCount = 16;
    localparam int LevelWidth  = 16;
    localparam int TimeWidth   = 32;
    localparam int IndexWidth  = 4;
    localparam int KindWidth   = 2;
    localparam int PortWidth   = 2;
    localparam int LaneCount   = (SensorCount > LevelWidth) ? LevelWidth :
                                 ((SensorCount < 1) ? 0 : SensorCount);
    localparam logic [LevelWidth-1:0] LaneMask =
        LevelWidth'((LevelWidth+1)'(1) << LaneCount) - LevelWidth'(1);

    // event kind codes
    localparam logic [KindWidth-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KindWidth-1:0] KIND_MOTION = 2'd1;
    localparam logic [KindWidth-1:0] KIND_CLEAR  = 2'd2;

    // expander port codes
    localparam logic [PortWidth-1:0] PORT_LOW  = 2'd1;
    localparam logic [PortWidth-1:0] PORT_HIGH = 2'd2;

    // scan sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } scan_state_t;

    // one event as it leaves the block
    typedef struct packed {
        logic [KindWidth-1:0]  event_kind;
        logic [IndexWidth-1:0] sensor_index;
        logic                  level_now;
        logic [PortWidth-1:0]  port_number;
        logic [TimeWidth-1:0]  event_time_ms;
        logic                  last_event;
    } event_t;

    // event beat from the scanner to the output stage
    typedef struct packed {
        logic   valid;
        event_t ev;
    } beat_t;

endpackage

### design/ices_snap_if.sv
// snapshot channel: sensor levels and timestamp with valid/ready
interface ices_snap_if;
    import ices_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LevelWidth-1:0] sensor_levels;
    logic [TimeWidth-1:0]  sample_time_ms;

    modport source (output valid, output sensor_levels, output sample_time_ms, input ready);
    modport sink   (input valid, input sensor_levels, input sample_time_ms, output ready);
endinterface

### design/ices_event_if.sv
// event channel: one change event per beat with valid/ready
interface ices_event_if;
    import ices_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KindWidth-1:0]  event_kind;
    logic [IndexWidth-1:0] sensor_index;
    logic                  level_now;
    logic [PortWidth-1:0]  port_number;
    logic [TimeWidth-1:0]  event_time_ms;
    logic                  last_event;

    modport source (output valid, output event_kind, output sensor_index, output level_now,
                    output port_number, output event_time_ms, output last_event,
                    input ready);
    modport sink   (input valid, input event_kind, input sensor_index, input level_now,
                    input port_number, input event_time_ms, input last_event,
                    output ready);
endinterface

### design/input_change_event_scanner.sv
// top level of the input change event scanner
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  snap    | in  | sensor_levels, sample_time_ms
//  evt     | out | event_kind, sensor_index, level_now, port_number,
//          |     | event_time_ms, last_event
//
// a snapshot with changes is scanned over all sixteen lanes, one sensor lane per
// cycle, holding a changed lane while the event sink stalls; a snapshot without
// changes leaves the scanner idle. the next snapshot is taken the cycle after the
// scan ends. the event output register lets the last event wait while a new snapshot
// is accepted. reset clears the previous levels and sticky first-detection flags.
module input_change_event_scanner (
    input  logic         clk,
    input  logic         rst_n,
    ices_snap_if.sink    snap,
    ices_event_if.source evt
);
    import ices_pkg::*;

    beat_t emit;
    logic  slot_free;

    // lane scanner
    ices_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap      (snap),
        .emit      (emit),
        .slot_free (slot_free)
    );

    // event output register
    ices_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .slot_free (slot_free),
        .evt       (evt)
    );

endmodule

### design/ices_scan.sv
// bit-serial change scanner: shifts diff, level and sticky flags one lane per cycle unless a changed lane stalls
module ices_scan (
    input  logic           clk,
    input  logic           rst_n,
    ices_snap_if.sink      snap,
    output ices_pkg::beat_t emit,
    input  logic           slot_free
);
    import ices_pkg::*;

    scan_state_t           state_reg, state_next;
    logic [IndexWidth-1:0] idx_reg;
    logic [LevelWidth-1:0] prev_reg;
    logic [LevelWidth-1:0] act_reg;
    logic [LevelWidth-1:0] diff_reg;
    logic [LevelWidth-1:0] lvl_reg;
    logic [TimeWidth-1:0]  stamp_reg;

    logic                  accept;
    logic [LevelWidth-1:0] now_lvl;
    logic [LevelWidth-1:0] load_diff;
    logic                  cur_diff;
    logic                  cur_lvl;
    logic                  cur_act;
    logic                  step;
    logic                  last_lane;

    // current lane sits at bit zero of each shift register
    assign accept    = snap.valid && snap.ready;
    assign now_lvl   = snap.sensor_levels & LaneMask;
    assign load_diff = (now_lvl ^ prev_reg) & LaneMask;
    assign cur_diff  = diff_reg[0];
    assign cur_lvl   = lvl_reg[0];
    assign cur_act   = act_reg[0];
    assign step      = (state_reg == ST_SCAN) && !(cur_diff && !slot_free);
    assign last_lane = (idx_reg == IndexWidth'(LevelWidth - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (load_diff != '0))
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (step && last_lane)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        snap.ready = 1'b0;
        emit       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                snap.ready = 1'b1;
            end
            ST_SCAN:
            begin
                emit.valid = cur_diff && slot_free;
            end
            default:
            begin
                snap.ready = 1'b0;
            end
        endcase
        // event payload for the current lane
        if (cur_diff && cur_lvl && !cur_act)
            emit.ev.event_kind = KIND_FIRST;
        else if (cur_lvl)
            emit.ev.event_kind = KIND_MOTION;
        else
            emit.ev.event_kind = KIND_CLEAR;
        emit.ev.sensor_index  = idx_reg;
        emit.ev.level_now     = cur_lvl;
        emit.ev.port_number   = idx_reg[IndexWidth-1] ? PORT_HIGH : PORT_LOW;
        emit.ev.event_time_ms = stamp_reg;
        emit.ev.last_event    = (diff_reg[LevelWidth-1:1] == '0);
    end

    // control state and sticky flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            prev_reg  <= '0;
            act_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                prev_reg <= now_lvl;
                idx_reg  <= '0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + IndexWidth'(1);
                // sticky flags rotate once around per scan
                act_reg <= {cur_act | (cur_diff & cur_lvl), act_reg[LevelWidth-1:1]};
            end
        end
    end

    // payload shift registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg  <= load_diff;
            lvl_reg   <= now_lvl;
            stamp_reg <= snap.sample_time_ms;
        end
        else if (step)
        begin
            diff_reg <= {1'b0, diff_reg[LevelWidth-1:1]};
            lvl_reg  <= {1'b0, lvl_reg[LevelWidth-1:1]};
        end
    end

endmodule

### design/ices_out_stage.sv
// output register holding one event beat until the sink takes it
module ices_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  ices_pkg::beat_t emit,
    output logic            slot_free,
    ices_event_if.source    evt
);
    import ices_pkg::*;

    logic   valid_reg;
    event_t ev_reg;

    // room for a new beat when empty or being drained
    assign slot_free = !valid_reg || evt.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (emit.valid)
            valid_reg <= 1'b1;
        else if (evt.ready)
            valid_reg <= 1'b0;
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (emit.valid)
            ev_reg <= emit.ev;
    end

    assign evt.valid         = valid_reg;
    assign evt.event_kind    = ev_reg.event_kind;
    assign evt.sensor_index  = ev_reg.sensor_index;
    assign evt.level_now     = ev_reg.level_now;
    assign evt.port_number   = ev_reg.port_number;
    assign evt.event_time_ms = ev_reg.event_time_ms;
    assign evt.last_event    = ev_reg.last_event;

endmodule

### design/ices_checker.sv
// port-level checks on the scanner and the bind that attaches them
module ices_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            evt_valid,
    input logic                            evt_ready,
    input logic [ices_pkg::KindWidth-1:0]  event_kind,
    input logic [ices_pkg::IndexWidth-1:0] sensor_index,
    input logic                            level_now,
    input logic [ices_pkg::PortWidth-1:0]  port_number,
    input logic [ices_pkg::TimeWidth-1:0]  event_time_ms,
    input logic                            last_event
);
    import ices_pkg::*;

    // a stalled event beat holds
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(event_kind)
            && $stable(sensor_index) && $stable(level_now)
            && $stable(event_time_ms) && $stable(last_event))
        else $error("event beat changed while stalled");

    // port follows the sensor index
    a_port: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> ((sensor_index[IndexWidth-1] && port_number == PORT_HIGH)
            || (!sensor_index[IndexWidth-1] && port_number == PORT_LOW)))
        else $error("port number does not match sensor index");

    // first detection and motion only on a high level
    a_kind_high: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && (event_kind == KIND_FIRST || event_kind == KIND_MOTION) |-> level_now)
        else $error("first detection or motion with low level");

    // clear only on a low level
    a_kind_low: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && event_kind == KIND_CLEAR |-> !level_now)
        else $error("clear event with high level");

    // events of one snapshot come in rising index order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready && !last_event
            |=> !evt_valid || sensor_index > $past(sensor_index))
        else $error("events out of index order");

endmodule

bind input_change_event_scanner ices_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .evt_valid     (evt.valid),
    .evt_ready     (evt.ready),
    .event_kind    (evt.event_kind),
    .sensor_index  (evt.sensor_index),
    .level_now     (evt.level_now),
    .port_number   (evt.port_number),
    .event_time_ms (evt.event_time_ms),
    .last_event    (evt.last_event)
);
